// ===== sv/crtc_pkg.sv =====
package crtc_pkg;

    localparam int NUM_REGS   = 16;
    localparam int REG_W      = 8;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 9;
    localparam int SYNC_W     = 5;
    localparam int OUT_ADDR_W = 14;
    localparam int LINE_W     = 8;
    localparam int TDATA_W    = 40;
    localparam int TUSER_IN_W = 3;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    localparam logic [3:0] REG_HTOTAL    = 4'd0;
    localparam logic [3:0] REG_HDISP     = 4'd1;
    localparam logic [3:0] REG_HSYNC_POS = 4'd2;
    localparam logic [3:0] REG_SYNC_W    = 4'd3;
    localparam logic [3:0] REG_VTOTAL    = 4'd4;
    localparam logic [3:0] REG_VADJUST   = 4'd5;
    localparam logic [3:0] REG_VDISP     = 4'd6;
    localparam logic [3:0] REG_VSYNC_POS = 4'd7;
    localparam logic [3:0] REG_MAX_LINE  = 4'd9;
    localparam logic [3:0] REG_CUR_START = 4'd10;
    localparam logic [3:0] REG_CUR_END   = 4'd11;
    localparam logic [3:0] REG_START_HI  = 4'd12;
    localparam logic [3:0] REG_START_LO  = 4'd13;
    localparam logic [3:0] REG_CUR_HI    = 4'd14;
    localparam logic [3:0] REG_CUR_LO    = 4'd15;

    localparam logic [1:0] BLINK_ON   = 2'd0;
    localparam logic [1:0] BLINK_OFF  = 2'd1;
    localparam logic [1:0] BLINK_FAST = 2'd2;
    localparam logic [1:0] BLINK_SLOW = 2'd3;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] t_regs;

    typedef struct packed {
        logic                  char_valid;
        logic [OUT_ADDR_W-1:0] char_address;
        logic [LINE_W-1:0]     char_scanline;
        logic                  cursor_hit;
        logic                  line_start;
        logic                  frame_start;
        logic                  hsync_level;
        logic                  vsync_level;
    } t_tick_res;

    function automatic logic [SYNC_W-1:0] sync_width(input logic [3:0] nibble);
        sync_width = (nibble == 4'd0) ? SYNC_W'(16) : {1'b0, nibble};
    endfunction

endpackage

// ===== sv/crtc_regfile.sv =====
module crtc_regfile
    import crtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic             i_port,
    input  logic [REG_W-1:0] i_data,
    output t_regs            o_regs,
    output logic [REG_W-1:0] o_read_data
);

    t_regs            r_regs;
    logic [IDX_W-1:0] r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= '0;
            r_index <= '0;
        end else if (i_wr_en) begin
            if (i_port == PORT_INDEX) begin
                r_index <= i_data[IDX_W-1:0];
            end else if (!r_index[IDX_W-1]) begin
                r_regs[r_index[IDX_W-2:0]] <= i_data;
            end
        end
    end

    always_comb begin
        o_read_data = '0;
        if (i_port == PORT_DATA &&
            (r_index == {1'b0, REG_CUR_HI} || r_index == {1'b0, REG_CUR_LO})) begin
            o_read_data = r_regs[r_index[IDX_W-2:0]];
        end
    end

    assign o_regs = r_regs;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en && i_port == PORT_INDEX |=> r_index == $past(i_data[IDX_W-1:0]))
        else $error("index write lost");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en && i_port == PORT_DATA && r_index[IDX_W-1] |=> $stable(r_regs))
        else $error("write beyond register file changed a register");

endmodule

// ===== sv/crtc_timing.sv =====
module crtc_timing
    import crtc_pkg::*;
#(
    parameter int ADDR_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_tick,
    input  logic      i_step,
    input  t_regs     i_regs,
    output t_tick_res o_res
);

    logic [CNT_W-1:0]     r_col, r_row, r_lir, r_adj;
    logic [SYNC_W-1:0]    r_hs_cnt, r_vs_cnt;
    logic                 r_hs_on, r_hdisp, r_vs_on, r_vdisp, r_adj_phase, r_cur_shown;
    logic [ADDR_BITS-1:0] r_da, r_rba;
    logic [REG_W-1:0]     r_blink;

    logic [CNT_W-1:0]     n_col, n_row, n_lir, n_adj;
    logic [SYNC_W-1:0]    n_hs_cnt, n_vs_cnt;
    logic                 n_hs_on, n_hdisp, n_vs_on, n_vdisp, n_adj_phase, n_cur_shown;
    logic [ADDR_BITS-1:0] n_da, n_rba;
    logic [REG_W-1:0]     n_blink;

    logic [2*REG_W-1:0]   w_start_pair, w_cur_pair;
    logic [ADDR_BITS-1:0] w_start, w_cur;
    logic [1:0]           w_mode;
    logic                 w_valid, w_line_end, w_frame;

    assign w_start_pair = {i_regs[REG_START_HI], i_regs[REG_START_LO]};
    assign w_cur_pair   = {i_regs[REG_CUR_HI], i_regs[REG_CUR_LO]};
    assign w_start      = w_start_pair[ADDR_BITS-1:0];
    assign w_cur        = w_cur_pair[ADDR_BITS-1:0];
    assign w_mode       = i_regs[REG_CUR_START][6:5];
    assign w_valid      = r_hdisp && r_vdisp;

    always_comb begin
        n_col       = r_col + CNT_W'(1);
        n_row       = r_row;
        n_lir       = r_lir;
        n_adj       = r_adj;
        n_hs_cnt    = r_hs_cnt;
        n_vs_cnt    = r_vs_cnt;
        n_hs_on     = r_hs_on;
        n_hdisp     = r_hdisp;
        n_vs_on     = r_vs_on;
        n_vdisp     = r_vdisp;
        n_adj_phase = r_adj_phase;
        n_cur_shown = r_cur_shown;
        n_da        = r_da;
        n_rba       = r_rba;
        n_blink     = r_blink;
        w_frame     = 1'b0;

        if (w_valid) begin
            n_da = r_da + ADDR_BITS'(1);
        end
        if (n_col >= {1'b0, i_regs[REG_HDISP]}) begin
            n_hdisp = 1'b0;
        end
        if (n_col == {1'b0, i_regs[REG_HSYNC_POS]}) begin
            n_hs_on  = 1'b1;
            n_hs_cnt = '0;
        end
        if (n_hs_on) begin
            n_hs_cnt = n_hs_cnt + SYNC_W'(1);
            if (n_hs_cnt >= sync_width(i_regs[REG_SYNC_W][3:0])) begin
                n_hs_on = 1'b0;
            end
        end

        w_line_end = n_col > {1'b0, i_regs[REG_HTOTAL]};
        if (w_line_end) begin
            n_col   = '0;
            n_hdisp = 1'b1;
            if (r_adj_phase) begin
                n_adj = r_adj + CNT_W'(1);
                if (n_adj >= {1'b0, i_regs[REG_VADJUST]}) begin
                    w_frame     = 1'b1;
                    n_adj_phase = 1'b0;
                    n_row       = '0;
                    n_lir       = '0;
                    n_vdisp     = 1'b1;
                    n_da        = w_start;
                    n_rba       = w_start;
                    case (w_mode)
                        BLINK_ON:  n_cur_shown = 1'b1;
                        BLINK_OFF: n_cur_shown = 1'b0;
                        default: begin
                            n_blink     = r_blink + REG_W'(1);
                            n_cur_shown = (w_mode == BLINK_FAST) ? !n_blink[4] : !n_blink[5];
                        end
                    endcase
                end
            end else begin
                n_lir = r_lir + CNT_W'(1);
                if (n_lir > {1'b0, i_regs[REG_MAX_LINE]}) begin
                    n_lir = '0;
                    n_row = r_row + CNT_W'(1);
                    n_rba = n_da;
                    if (n_row >= {1'b0, i_regs[REG_VDISP]}) begin
                        n_vdisp = 1'b0;
                    end
                    if (n_row == {1'b0, i_regs[REG_VSYNC_POS]}) begin
                        n_vs_on  = 1'b1;
                        n_vs_cnt = '0;
                    end
                    if (n_row > {1'b0, i_regs[REG_VTOTAL]}) begin
                        n_adj_phase = 1'b1;
                        n_adj       = '0;
                        n_vs_on     = 1'b0;
                    end
                end else begin
                    n_da = r_rba;
                end
            end
            if (n_vs_on) begin
                n_vs_cnt = n_vs_cnt + SYNC_W'(1);
                if (n_vs_cnt >= sync_width(i_regs[REG_SYNC_W][7:4])) begin
                    n_vs_on = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_lir       <= '0;
            r_adj       <= '0;
            r_hs_cnt    <= '0;
            r_vs_cnt    <= '0;
            r_hs_on     <= 1'b0;
            r_hdisp     <= 1'b0;
            r_vs_on     <= 1'b0;
            r_vdisp     <= 1'b0;
            r_adj_phase <= 1'b0;
            r_cur_shown <= 1'b1;
            r_da        <= '0;
            r_rba       <= '0;
            r_blink     <= '0;
        end else if (i_step) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_lir       <= n_lir;
            r_adj       <= n_adj;
            r_hs_cnt    <= n_hs_cnt;
            r_vs_cnt    <= n_vs_cnt;
            r_hs_on     <= n_hs_on;
            r_hdisp     <= n_hdisp;
            r_vs_on     <= n_vs_on;
            r_vdisp     <= n_vdisp;
            r_adj_phase <= n_adj_phase;
            r_cur_shown <= n_cur_shown;
            r_da        <= n_da;
            r_rba       <= n_rba;
            r_blink     <= n_blink;
        end
    end

    always_comb begin
        o_res             = '0;
        o_res.hsync_level = r_hs_on;
        o_res.vsync_level = r_vs_on;
        if (i_tick) begin
            o_res.hsync_level = n_hs_on;
            o_res.vsync_level = n_vs_on;
            o_res.line_start  = w_line_end;
            o_res.frame_start = w_frame;
            if (w_valid) begin
                o_res.char_valid    = 1'b1;
                o_res.char_address  = r_da[OUT_ADDR_W-1:0];
                o_res.char_scanline = r_lir[LINE_W-1:0];
                o_res.cursor_hit    = r_cur_shown && (r_da == w_cur) &&
                    (r_lir >= {4'd0, i_regs[REG_CUR_START][4:0]}) &&
                    (r_lir <= {1'b0, i_regs[REG_CUR_END]});
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_line_end |=> r_col == '0 && r_hdisp)
        else $error("line end did not restart the column");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_frame |=> r_vdisp && !r_adj_phase && r_row == '0 && r_lir == '0)
        else $error("new frame did not restart the vertical counters");

endmodule

// ===== sv/crt_timing_controller.sv =====
// channel  | dir | beat fields (low bit first)
// s_axis   | in  | tdata: write_data[7:0]; tuser: req_type[1:0], port_select[2]
// m_axis   | out | tdata: read_data[7:0], char_valid[8], char_address[22:9],
//          |     |   char_scanline[30:23], cursor_hit[31], line_start[32],
//          |     |   frame_start[33], hsync_level[34], vsync_level[35], zero[39:36]
// one result beat per input beat, registered first in the input register, then in the result register
// one beat per cycle sustained while m_axis_tready is high; input register feeds the result register directly
// reset clears all timing registers and R0-R15, cursor shown
// a stalled result holds the input register; s_axis_tready drops only when both are full
module crt_timing_controller
    import crtc_pkg::*;
#(
    parameter int ADDR_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [REG_W-1:0]      s_axis_tdata,  // write_data
    input  logic [TUSER_IN_W-1:0] s_axis_tuser,  // req_type, port_select
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata   // read_data .. vsync_level, zero pad
);

    logic             r_in_valid;
    t_req             r_in_req;
    logic             r_in_port;
    logic [REG_W-1:0] r_in_data;

    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;

    logic             w_adv;
    logic             w_tick;
    t_regs            w_regs;
    logic [REG_W-1:0] w_rd;
    logic [REG_W-1:0] w_read_data;
    t_tick_res        w_res;
    logic [TDATA_W-1:0] n_out_data;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_tick        = r_in_valid && (r_in_req == REQ_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req  <= t_req'(s_axis_tuser[1:0]);
            r_in_port <= s_axis_tuser[2];
            r_in_data <= s_axis_tdata;
        end
    end

    crtc_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_adv && r_in_req == REQ_WRITE),
        .i_port      (r_in_port),
        .i_data      (r_in_data),
        .o_regs      (w_regs),
        .o_read_data (w_rd)
    );

    crtc_timing #(
        .ADDR_BITS (ADDR_BITS)
    ) u_timing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_step  (w_adv && w_tick),
        .i_regs  (w_regs),
        .o_res   (w_res)
    );

    assign w_read_data = (r_in_req == REQ_READ) ? w_rd : '0;

    assign n_out_data = {4'd0, w_res.vsync_level, w_res.hsync_level, w_res.frame_start,
                         w_res.line_start, w_res.cursor_hit, w_res.char_scanline,
                         w_res.char_address, w_res.char_valid, w_read_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages are full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[33] |-> r_out_data[32])
        else $error("frame start without line end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data[8] |-> r_out_data[31:9] == '0)
        else $error("character fields set outside active area");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("stalled input beat dropped");

endmodule
